// ----- rtl/cds_pkg.sv -----
// Shared types, constants and calendar helper functions for the date stepper.
package cds_pkg;

  localparam int unsigned MAX_STEP = 4095;
  localparam int unsigned CNT_W    = $clog2(MAX_STEP + 1);

  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned STEP_W   = 13;
  localparam int unsigned DOY_W    = 9;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 56;

  localparam logic [YEAR_W-1:0]  YEAR_MIN  = 14'd1700;
  localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
  localparam logic [MONTH_W-1:0] MONTH_MIN = 4'd3;
  localparam logic [DAY_W-1:0]   DAY_MAX   = 5'd31;

  // Reciprocal constants: y / 100 = (y * 5243) >> 19 for y <= 9999,
  // t / 7 = (t * 9363) >> 16 for t < 13110.
  localparam int unsigned        MUL_W     = 14;
  localparam logic [MUL_W-1:0]   RECIP_100 = 14'd5243;
  localparam logic [MUL_W-1:0]   RECIP_7   = 14'd9363;
  localparam int unsigned        SHIFT_100 = 19;
  localparam int unsigned        SHIFT_7   = 16;

  // Weekday sum of 1700-03-01 plus one for the day-minus-one term.
  localparam logic [15:0]        EPOCH_SUM = 16'd2113;

  typedef enum logic [0:0] {
    REQ_LOAD = 1'b0,
    REQ_MOVE = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CLAMP   = 2'd1,
    ST_IGNORED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CENT,
    S_SPLIT,
    S_WSUM,
    S_WMOD,
    S_STEP,
    S_FIN
  } state_t;

  // Leap test from the low two year bits, year mod 100 and the low two century bits.
  function automatic logic is_leap(input logic [1:0] y_lo2, input logic [6:0] ylo,
                                   input logic [1:0] cent_lo2);
    is_leap = (y_lo2 == 2'd0) && ((ylo != 7'd0) || (cent_lo2 == 2'd0));
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m, input logic lp);
    case (m)
      4'd2:                   month_len = lp ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: month_len = 5'd30;
      default:                month_len = 5'd31;
    endcase
  endfunction

  function automatic logic date_ok(input logic [YEAR_W-1:0] y, input logic [MONTH_W-1:0] m,
                                   input logic [DAY_W-1:0] d, input logic lp);
    date_ok = (y >= YEAR_MIN) && (y <= YEAR_MAX) && (m >= 4'd1) && (m <= 4'd12) &&
              !((y == YEAR_MIN) && (m < MONTH_MIN)) &&
              (d >= 5'd1) && (d <= month_len(m, lp));
  endfunction

  function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] m);
    case (m)
      4'd2:    month_start = 9'd31;
      4'd3:    month_start = 9'd59;
      4'd4:    month_start = 9'd90;
      4'd5:    month_start = 9'd120;
      4'd6:    month_start = 9'd151;
      4'd7:    month_start = 9'd181;
      4'd8:    month_start = 9'd212;
      4'd9:    month_start = 9'd243;
      4'd10:   month_start = 9'd273;
      4'd11:   month_start = 9'd304;
      4'd12:   month_start = 9'd334;
      default: month_start = 9'd0;
    endcase
  endfunction

  // Days from March 1 to the first of the month, with March as month zero.
  function automatic logic [DOY_W-1:0] month_term(input logic [MONTH_W-1:0] m);
    case (m)
      4'd4:    month_term = 9'd31;
      4'd5:    month_term = 9'd61;
      4'd6:    month_term = 9'd92;
      4'd7:    month_term = 9'd122;
      4'd8:    month_term = 9'd153;
      4'd9:    month_term = 9'd184;
      4'd10:   month_term = 9'd214;
      4'd11:   month_term = 9'd245;
      4'd12:   month_term = 9'd275;
      4'd1:    month_term = 9'd306;
      4'd2:    month_term = 9'd337;
      default: month_term = 9'd0;
    endcase
  endfunction

  function automatic logic [2:0] quarter_of(input logic [MONTH_W-1:0] m);
    case (m)
      4'd1, 4'd2, 4'd3:    quarter_of = 3'd1;
      4'd4, 4'd5, 4'd6:    quarter_of = 3'd2;
      4'd7, 4'd8, 4'd9:    quarter_of = 3'd3;
      4'd10, 4'd11, 4'd12: quarter_of = 3'd4;
      default:             quarter_of = 3'd0;
    endcase
  endfunction

endpackage

// ----- rtl/calendar_date_stepper_unit.sv -----
// Top level of the calendar date stepper: sequencer, day stepper and shared multiplier.
//
// The unit holds a Gregorian date and weekday, reset to Monday 1700-03-01. A load beat
// stores a raw date; its weekday comes from two reciprocal multiplications on one shared
// 14x14 multiplier in S_CENT, S_SPLIT, S_WSUM and, for a valid date, S_WMOD. A move beat
// walks the date one day per clock in S_STEP, with the count saturated at 4095 and cut
// short at 1700-03-01 or 9999-12-31. A move from an invalid date goes straight to S_FIN
// with status ignored. One beat is in flight at a time; in_tready is high whenever the
// sequencer is idle, even while a finished result still waits on the output register.
module calendar_date_stepper_unit
  import cds_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // load_year[13:0], load_month[17:14], load_day[22:18], step_count[35:23], zero fill
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // req_type[0]
  input  logic [0:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // year[13:0], month[17:14], day[22:18], date_valid[23], leap_year[24],
  // day_of_year[33:25], days_left[42:34], quarter[45:43], weekday[48:46],
  // status[50:49], zero fill
  output logic [OUT_DATA_W-1:0] out_tdata
);

  state_t              state_r, state_nxt;
  logic [YEAR_W-1:0]   year_r, year_nxt;
  logic [MONTH_W-1:0]  month_r, month_nxt;
  logic [DAY_W-1:0]    day_r, day_nxt;
  logic [7:0]          cent_r, cent_nxt;
  logic [6:0]          ylo_r, ylo_nxt;
  logic [2:0]          wday_r, wday_nxt;
  status_t             status_r, status_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                back_r, back_nxt;
  logic [2*MUL_W-1:0]  prod_r, prod_nxt;
  logic [MUL_W-1:0]    t_r, t_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic                in_acc;
  logic                out_free;
  logic                lp;
  logic                cur_ok;
  logic [DAY_W-1:0]    cur_mlen;
  logic                at_min, at_max;

  logic [STEP_W-1:0]   step_raw;
  logic [STEP_W-1:0]   step_mag;
  logic                step_back;

  logic                early;
  logic [YEAR_W-1:0]   yy;
  logic [7:0]          yy_cent;
  logic [15:0]         wsum;
  logic [7:0]          cent_split;
  logic [14:0]         cent_x100;

  logic [MUL_W-1:0]    mul_a, mul_k;
  logic [2*MUL_W-1:0]  mul_p;
  logic [MUL_W-1:0]    q7;
  logic [MUL_W-1:0]    rem7;

  logic [DOY_W-1:0]    doy, left;

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  assign lp       = is_leap(year_r[1:0], ylo_r, cent_r[1:0]);
  assign cur_ok   = date_ok(year_r, month_r, day_r, lp);
  assign cur_mlen = month_len(month_r, lp);
  assign at_min   = (year_r == YEAR_MIN) && (month_r == MONTH_MIN) && (day_r == 5'd1);
  assign at_max   = (year_r == YEAR_MAX) && (month_r == 4'd12) && (day_r == DAY_MAX);

  assign step_raw  = in_tdata[35:23];
  assign step_back = step_raw[STEP_W-1];
  assign step_mag  = step_back ? (~step_raw + 1'b1) : step_raw;

  // January and February count with the previous year in the weekday sum.
  assign early   = (month_r <= 4'd2);
  assign yy      = early ? (year_r - 1'b1) : year_r;
  assign yy_cent = (early && (ylo_r == 7'd0)) ? (cent_r - 1'b1) : cent_r;
  assign wsum    = {2'b0, yy} + {4'b0, yy[YEAR_W-1:2]} - {8'b0, yy_cent}
                 + {10'b0, yy_cent[7:2]} + {7'b0, month_term(month_r)}
                 + {11'b0, day_r} - EPOCH_SUM;

  assign cent_split = prod_r[SHIFT_100+7:SHIFT_100];
  assign cent_x100  = {7'b0, cent_split} * 15'd100;

  // One multiplier serves the century split and the weekday reduction.
  assign mul_a = (state_r == S_CENT) ? year_r : wsum[MUL_W-1:0];
  assign mul_k = (state_r == S_CENT) ? RECIP_100 : RECIP_7;
  assign mul_p = {{MUL_W{1'b0}}, mul_a} * {{MUL_W{1'b0}}, mul_k};

  assign q7   = {{(MUL_W-(2*MUL_W-SHIFT_7)){1'b0}}, prod_r[2*MUL_W-1:SHIFT_7]};
  assign rem7 = t_r - ((q7 << 3) - q7);

  assign doy  = {4'b0, day_r} + month_start(month_r) + {8'b0, (lp && (month_r > 4'd2))};
  assign left = (lp ? 9'd366 : 9'd365) - doy;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser[0] == REQ_LOAD) begin
            state_nxt = S_CENT;
          end else if (cur_ok) begin
            state_nxt = S_STEP;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_CENT:  state_nxt = S_SPLIT;
      S_SPLIT: state_nxt = S_WSUM;
      S_WSUM:  state_nxt = cur_ok ? S_WMOD : S_FIN;
      S_WMOD:  state_nxt = S_FIN;
      S_STEP: begin
        if ((cnt_r == '0) || (back_r ? at_min : at_max)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    year_nxt      = year_r;
    month_nxt     = month_r;
    day_nxt       = day_r;
    cent_nxt      = cent_r;
    ylo_nxt       = ylo_r;
    wday_nxt      = wday_r;
    status_nxt    = status_r;
    cnt_nxt       = cnt_r;
    back_nxt      = back_r;
    prod_nxt      = prod_r;
    t_nxt         = t_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          status_nxt = ST_OK;
          if (in_tuser[0] == REQ_LOAD) begin
            year_nxt  = in_tdata[13:0];
            month_nxt = in_tdata[17:14];
            day_nxt   = in_tdata[22:18];
          end else if (cur_ok) begin
            back_nxt = step_back;
            cnt_nxt  = (step_mag > STEP_W'(MAX_STEP)) ? CNT_W'(MAX_STEP)
                                                      : step_mag[CNT_W-1:0];
          end else begin
            status_nxt = ST_IGNORED;
          end
        end
      end
      S_CENT: begin
        prod_nxt = mul_p;
      end
      S_SPLIT: begin
        // Century and year mod 100 both come from the same product, so the leap
        // test and the weekday sum see a settled year in the next state.
        cent_nxt = cent_split;
        ylo_nxt  = year_r[6:0] - cent_x100[6:0];
      end
      S_WSUM: begin
        t_nxt    = wsum[MUL_W-1:0];
        prod_nxt = mul_p;
        if (!cur_ok) begin
          wday_nxt = 3'd0;
        end
      end
      S_WMOD: begin
        wday_nxt = rem7[2:0] + 3'd1;
      end
      S_STEP: begin
        if (cnt_r != '0) begin
          if (back_r ? at_min : at_max) begin
            status_nxt = ST_CLAMP;
          end else if (!back_r) begin
            cnt_nxt  = cnt_r - 1'b1;
            wday_nxt = (wday_r == 3'd7) ? 3'd1 : wday_r + 3'd1;
            if (day_r == cur_mlen) begin
              day_nxt = 5'd1;
              if (month_r == 4'd12) begin
                month_nxt = 4'd1;
                year_nxt  = year_r + 1'b1;
                if (ylo_r == 7'd99) begin
                  ylo_nxt  = 7'd0;
                  cent_nxt = cent_r + 1'b1;
                end else begin
                  ylo_nxt = ylo_r + 1'b1;
                end
              end else begin
                month_nxt = month_r + 1'b1;
              end
            end else begin
              day_nxt = day_r + 1'b1;
            end
          end else begin
            cnt_nxt  = cnt_r - 1'b1;
            wday_nxt = (wday_r == 3'd1) ? 3'd7 : wday_r - 3'd1;
            if (day_r == 5'd1) begin
              if (month_r == 4'd1) begin
                month_nxt = 4'd12;
                day_nxt   = DAY_MAX;
                year_nxt  = year_r - 1'b1;
                if (ylo_r == 7'd0) begin
                  ylo_nxt  = 7'd99;
                  cent_nxt = cent_r - 1'b1;
                end else begin
                  ylo_nxt = ylo_r - 1'b1;
                end
              end else begin
                month_nxt = month_r - 1'b1;
                day_nxt   = month_len(month_r - 1'b1, lp);
              end
            end else begin
              day_nxt = day_r - 1'b1;
            end
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt[13:0]  = year_r;
          out_data_nxt[17:14] = month_r;
          out_data_nxt[22:18] = day_r;
          if (cur_ok) begin
            out_data_nxt[23]    = 1'b1;
            out_data_nxt[24]    = lp;
            out_data_nxt[33:25] = doy;
            out_data_nxt[42:34] = left;
            out_data_nxt[45:43] = quarter_of(month_r);
            out_data_nxt[48:46] = wday_r;
          end
          out_data_nxt[50:49] = status_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      year_r      <= YEAR_MIN;
      month_r     <= MONTH_MIN;
      day_r       <= 5'd1;
      cent_r      <= 8'd17;
      ylo_r       <= 7'd0;
      wday_r      <= 3'd1;
      status_r    <= ST_OK;
      cnt_r       <= '0;
      back_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      year_r      <= year_nxt;
      month_r     <= month_nxt;
      day_r       <= day_nxt;
      cent_r      <= cent_nxt;
      ylo_r       <= ylo_nxt;
      wday_r      <= wday_nxt;
      status_r    <= status_nxt;
      cnt_r       <= cnt_nxt;
      back_r      <= back_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r     <= prod_nxt;
    t_r        <= t_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
